// ===== hw/rtl/sbfr_pkg.sv =====
`default_nettype none

package sbfr_pkg;

    // Frame layout
    localparam int FRAME_BYTES  = 25;
    localparam int NUM_CHANNELS = 16;
    localparam int STORE_DEPTH  = FRAME_BYTES - 1;
    localparam int STORE_AW     = $clog2(STORE_DEPTH);
    localparam int CNT_W        = $clog2(FRAME_BYTES + 1);
    localparam int FLAG_IDX     = 22;

    localparam logic [7:0] START_MARK = 8'h0F;
    localparam logic [7:0] END_MARK   = 8'h00;

    // Channel unpacking
    localparam int CH_BITS  = 11;
    localparam int CH_IDX_W = 4;
    localparam int BUF_W    = CH_BITS + 7;
    localparam int NBITS_W  = $clog2(BUF_W + 1);

    // Linear map raw*GAIN/SPAN + LOW, division done by reciprocal multiply
    localparam int MAP_IN_SPAN  = 2014;
    localparam int MAP_OUT_LOW  = -1210;
    localparam int MAP_OUT_HIGH = 1250;
    localparam int MAP_GAIN     = MAP_OUT_HIGH - MAP_OUT_LOW;
    localparam int PROD_W       = 23;
    localparam int RECIP_SHIFT  = 34;
    localparam int RECIP_W      = 24;
    localparam longint unsigned MAP_RECIP =
        ((64'd1 << RECIP_SHIFT) + 64'(MAP_IN_SPAN) - 64'd1) / 64'(MAP_IN_SPAN);
    localparam int QUOT_W       = 12;
    localparam int SCALED_W     = 12;

    // Link timing
    localparam logic [15:0] AGE_MAX       = 16'hFFFF;
    localparam logic [15:0] TIMEOUT_RESET = 16'd20;

    // Input command and result kind codes
    localparam logic CMD_BYTE  = 1'b0;
    localparam logic CMD_TICK  = 1'b1;
    localparam logic KIND_CHAN = 1'b0;
    localparam logic KIND_LINK = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FLAG_RD,
        ST_FLAG_CAP,
        ST_BYTE_RD,
        ST_BYTE_CAP,
        ST_SCALE_PROD,
        ST_SCALE_QUOT,
        ST_CHAN_EMIT,
        ST_TICK_EMIT
    } rx_state_t;

    typedef struct packed {
        logic prod_en;
        logic quot_en;
    } scale_ctl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sbfr_scale.sv =====
`default_nettype none

module sbfr_scale
    import sbfr_pkg::*;
(
    input  wire logic                       clk,
    input  wire scale_ctl_t                 ctl,
    input  wire logic [CH_BITS-1:0]         raw,
    output logic signed [SCALED_W-1:0]      scaled
);

    logic [PROD_W-1:0]               prod_reg;
    logic                            zero_reg;
    logic [QUOT_W-1:0]               quot_reg;
    logic                            zero_q_reg;
    logic [PROD_W+RECIP_W-1:0]       recip_prod;
    logic signed [SCALED_W:0]        offset_sum;

    // Stage 1: raw times output span
    always_ff @(posedge clk)
    begin
        if (ctl.prod_en)
        begin
            prod_reg <= PROD_W'(raw) * PROD_W'(MAP_GAIN);
            zero_reg <= (raw == '0);
        end
    end

    // Stage 2: divide by input span through reciprocal multiply
    assign recip_prod = (PROD_W+RECIP_W)'(prod_reg) * (PROD_W+RECIP_W)'(RECIP_W'(MAP_RECIP));

    always_ff @(posedge clk)
    begin
        if (ctl.quot_en)
        begin
            quot_reg   <= recip_prod[RECIP_SHIFT +: QUOT_W];
            zero_q_reg <= zero_reg;
        end
    end

    // Add the output offset; raw zero maps to zero
    assign offset_sum = $signed({1'b0, quot_reg}) + (SCALED_W+1)'(MAP_OUT_LOW);
    assign scaled     = zero_q_reg ? '0 : offset_sum[SCALED_W-1:0];

endmodule

`default_nettype wire

// ===== hw/rtl/sbus_frame_receiver.sv =====
`default_nettype none
// SBUS frame receiver.
// Input channel (in_valid/in_stall): one item per received serial byte
// (command 0, data_byte) or per millisecond tick (command 1).
// Output channel (out_valid/out_stall): one item per result, last marks the
// final result of an input item. A tick gives one link status item, loaded into
// the output register from the tick emit state. A good frame (start 0x0F, 23
// stored bytes, end 0x00) gives 16 channel items; the frame bytes sit in a
// 24-entry store that is read back one byte at a time, each byte read and then
// captured, and each channel passes through the two-stage scaler before it is
// emitted. While results are produced in_stall is high; ordinary bytes are
// taken without stall. Configuration: timeout_ticks is written with cfg_valid
// and cfg_ready (always ready); the user must write it only while the block is
// idle, and the block itself does not enforce this.
// Reset hunts for a start byte, marks the link as lost and sets the timeout
// to 20 ticks. When the receiver stalls, the output register holds its item
// and the sequencer waits.
module sbus_frame_receiver
    import sbfr_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    // input items
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic                       command,
    input  wire logic [7:0]                 data_byte,
    // configuration
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [15:0]                timeout_ticks,
    // result items
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic                            result_kind,
    output logic [CH_IDX_W-1:0]             channel_index,
    output logic [CH_BITS-1:0]              raw_value,
    output logic signed [SCALED_W-1:0]      scaled_value,
    output logic                            digital_one,
    output logic                            digital_two,
    output logic                            frame_lost,
    output logic                            failsafe,
    output logic                            link_alive,
    output logic                            last
);

    rx_state_t                  state_reg, state_next;
    logic [CNT_W-1:0]           byte_count_reg, byte_count_next;
    logic [15:0]                link_age_reg, link_age_next;
    logic [15:0]                timeout_reg;
    logic [STORE_AW-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [CH_IDX_W-1:0]        ch_reg, ch_next;
    logic [BUF_W-1:0]           buf_reg, buf_next;
    logic [NBITS_W-1:0]         nbits_reg, nbits_next;
    logic [3:0]                 flags_reg, flags_next;
    logic [CH_BITS-1:0]         raw_reg, raw_next;

    logic [7:0]                 store_mem [STORE_DEPTH];
    logic [7:0]                 rdata_reg;
    logic                       mem_we;
    logic                       mem_re;
    logic [STORE_AW-1:0]        wr_addr;
    logic [STORE_AW-1:0]        rd_addr;

    logic                       in_fire;
    logic                       frame_end;
    logic                       frame_good;
    logic                       slot_free;
    logic                       alive;
    logic                       ch_ready;
    logic                       last_ch;
    logic                       load_chan;
    logic                       load_link;
    scale_ctl_t                 scale_ctl;
    logic signed [SCALED_W-1:0] scaled;

    logic                       out_valid_reg;
    logic                       kind_reg;
    logic [CH_IDX_W-1:0]        idx_reg;
    logic [CH_BITS-1:0]         raw_out_reg;
    logic signed [SCALED_W-1:0] scaled_out_reg;
    logic [3:0]                 flags_out_reg;
    logic                       alive_reg;
    logic                       last_reg;

    // Handshake decode
    assign in_stall   = (state_reg != ST_IDLE);
    assign cfg_ready  = 1'b1;
    assign in_fire    = in_valid && !in_stall;
    assign frame_end  = in_fire && (command == CMD_BYTE)
                        && (byte_count_reg == CNT_W'(STORE_DEPTH));
    assign frame_good = frame_end && (data_byte == END_MARK);
    assign slot_free  = !out_valid_reg || !out_stall;
    assign alive      = (link_age_reg < timeout_reg);
    assign ch_ready   = (nbits_reg >= NBITS_W'(CH_BITS));
    assign last_ch    = (ch_reg == CH_IDX_W'(NUM_CHANNELS - 1));
    assign wr_addr    = STORE_AW'(byte_count_reg - CNT_W'(1));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && (command == CMD_TICK))
                begin
                    state_next = ST_TICK_EMIT;
                end
                else if (frame_good)
                begin
                    state_next = ST_FLAG_RD;
                end
            end
            ST_FLAG_RD:    state_next = ST_FLAG_CAP;
            ST_FLAG_CAP:   state_next = ST_BYTE_RD;
            ST_BYTE_RD:    state_next = ST_BYTE_CAP;
            ST_BYTE_CAP:
            begin
                if ((nbits_reg + NBITS_W'(8)) >= NBITS_W'(CH_BITS))
                begin
                    state_next = ST_SCALE_PROD;
                end
                else
                begin
                    state_next = ST_BYTE_RD;
                end
            end
            ST_SCALE_PROD: state_next = ST_SCALE_QUOT;
            ST_SCALE_QUOT: state_next = ST_CHAN_EMIT;
            ST_CHAN_EMIT:
            begin
                if (slot_free)
                begin
                    if (last_ch)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (ch_ready)
                    begin
                        state_next = ST_SCALE_PROD;
                    end
                    else
                    begin
                        state_next = ST_BYTE_RD;
                    end
                end
            end
            ST_TICK_EMIT:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:       state_next = ST_IDLE;
        endcase
    end

    // State outputs: memory access, scaler control, register updates
    always_comb
    begin
        byte_count_next   = byte_count_reg;
        link_age_next     = link_age_reg;
        rd_ptr_next       = rd_ptr_reg;
        ch_next           = ch_reg;
        buf_next          = buf_reg;
        nbits_next        = nbits_reg;
        flags_next        = flags_reg;
        raw_next          = raw_reg;
        mem_we            = 1'b0;
        mem_re            = 1'b0;
        rd_addr           = rd_ptr_reg;
        scale_ctl.prod_en = 1'b0;
        scale_ctl.quot_en = 1'b0;
        load_chan         = 1'b0;
        load_link         = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (command == CMD_TICK)
                    begin
                        if (link_age_reg != AGE_MAX)
                        begin
                            link_age_next = link_age_reg + 16'd1;
                        end
                    end
                    else if (byte_count_reg == '0)
                    begin
                        if (data_byte == START_MARK)
                        begin
                            byte_count_next = CNT_W'(1);
                        end
                    end
                    else if (byte_count_reg > CNT_W'(STORE_DEPTH))
                    begin
                        byte_count_next = '0;
                    end
                    else
                    begin
                        mem_we = 1'b1;
                        if (frame_good)
                        begin
                            byte_count_next = '0;
                            link_age_next   = '0;
                            rd_ptr_next     = '0;
                            ch_next         = '0;
                            buf_next        = '0;
                            nbits_next      = '0;
                        end
                        else if (frame_end)
                        begin
                            byte_count_next = CNT_W'(1);
                            link_age_next   = AGE_MAX;
                        end
                        else
                        begin
                            byte_count_next = byte_count_reg + CNT_W'(1);
                        end
                    end
                end
            end
            ST_FLAG_RD:
            begin
                mem_re  = 1'b1;
                rd_addr = STORE_AW'(FLAG_IDX);
            end
            ST_FLAG_CAP:
            begin
                flags_next = rdata_reg[3:0];
            end
            ST_BYTE_RD:
            begin
                mem_re      = 1'b1;
                rd_ptr_next = rd_ptr_reg + STORE_AW'(1);
            end
            ST_BYTE_CAP:
            begin
                buf_next   = buf_reg | (BUF_W'(rdata_reg) << nbits_reg);
                nbits_next = nbits_reg + NBITS_W'(8);
            end
            ST_SCALE_PROD:
            begin
                scale_ctl.prod_en = 1'b1;
                raw_next          = buf_reg[CH_BITS-1:0];
                buf_next          = buf_reg >> CH_BITS;
                nbits_next        = nbits_reg - NBITS_W'(CH_BITS);
            end
            ST_SCALE_QUOT:
            begin
                scale_ctl.quot_en = 1'b1;
            end
            ST_CHAN_EMIT:
            begin
                if (slot_free)
                begin
                    load_chan = 1'b1;
                    ch_next   = ch_reg + CH_IDX_W'(1);
                end
            end
            ST_TICK_EMIT:
            begin
                load_link = slot_free;
            end
            default:
            begin
                mem_re = 1'b0;
            end
        endcase
    end

    // Frame byte store
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[wr_addr] <= data_byte;
        end
        if (mem_re)
        begin
            rdata_reg <= store_mem[rd_addr];
        end
    end

    // Channel scaler
    sbfr_scale u_scale (
        .clk    (clk),
        .ctl    (scale_ctl),
        .raw    (buf_reg[CH_BITS-1:0]),
        .scaled (scaled)
    );

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            byte_count_reg <= '0;
            link_age_reg   <= AGE_MAX;
            timeout_reg    <= TIMEOUT_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            byte_count_reg <= byte_count_next;
            link_age_reg   <= link_age_next;
            if (cfg_valid && cfg_ready)
            begin
                timeout_reg <= timeout_ticks;
            end
            if (load_chan || load_link)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        rd_ptr_reg <= rd_ptr_next;
        ch_reg     <= ch_next;
        buf_reg    <= buf_next;
        nbits_reg  <= nbits_next;
        flags_reg  <= flags_next;
        raw_reg    <= raw_next;
    end

    // Output item register
    always_ff @(posedge clk)
    begin
        if (load_chan)
        begin
            kind_reg       <= KIND_CHAN;
            idx_reg        <= ch_reg;
            raw_out_reg    <= raw_reg;
            scaled_out_reg <= scaled;
            flags_out_reg  <= flags_reg;
            alive_reg      <= alive;
            last_reg       <= last_ch;
        end
        else if (load_link)
        begin
            kind_reg       <= KIND_LINK;
            idx_reg        <= '0;
            raw_out_reg    <= '0;
            scaled_out_reg <= '0;
            flags_out_reg  <= '0;
            alive_reg      <= alive;
            last_reg       <= 1'b1;
        end
    end

    assign out_valid     = out_valid_reg;
    assign result_kind   = kind_reg;
    assign channel_index = idx_reg;
    assign raw_value     = raw_out_reg;
    assign scaled_value  = scaled_out_reg;
    assign digital_one   = flags_out_reg[0];
    assign digital_two   = flags_out_reg[1];
    assign frame_lost    = flags_out_reg[2];
    assign failsafe      = flags_out_reg[3];
    assign link_alive    = alive_reg;
    assign last          = last_reg;

endmodule

`default_nettype wire
